>>> hdl/trim_pkg.sv
// Shared widths, status codes and divider stage type for the two-ray midpoint block.
package trim_pkg;

  localparam int AXES      = 3;
  localparam int POS_W     = 32;                 // Q16.16 positions
  localparam int DIR_W     = 18;                 // Q2.16 directions
  localparam int THR_W     = 32;
  localparam int DATA_W    = 32;
  localparam int ADDR_W    = 3;
  localparam int REG_IDX_W = ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_PAR_THR = 1'b0;

  localparam int DIF_W     = POS_W + 1;          // origin difference and sum
  localparam int CP_W      = 2 * DIR_W;          // direction products
  localparam int C_W       = CP_W + 1;           // cross product components
  localparam int UP_W      = DIF_W + DIR_W;      // difference x direction products
  localparam int U_W       = UP_W + 1;
  localparam int ULO_W     = 26;                 // low split of U
  localparam int DD_W      = 72;                 // squared cross length
  localparam int DEN_SHIFT = 32;
  localparam int DEN_W     = DD_W - DEN_SHIFT;
  localparam int PL_W      = C_W + ULO_W + 1;
  localparam int PH_W      = C_W + U_W - ULO_W;
  localparam int SL_W      = PL_W + 2;
  localparam int SH_W      = PH_W + 2;
  localparam int N_W       = SH_W + ULO_W + 1;   // closest-point numerators
  localparam int NC_W      = 31;                 // numerator chunk
  localparam int PN_W      = NC_W + 1 + DIR_W;
  localparam int PN2_W     = N_W - 2 * NC_W + DIR_W;
  localparam int DC_W      = DEN_W / 2;
  localparam int PD_W      = DIF_W + DC_W + 1;
  localparam int S_W       = 112;                // midpoint numerator
  localparam int SHR       = 33;
  localparam int SV_W      = S_W - SHR;
  localparam int UD_W      = SV_W - 1;
  localparam int QB        = POS_W - 1;          // quotient bits below saturation

  localparam int PIPE_LAT  = 9;
  localparam int DIV_LAT   = QB + 2;
  localparam int TOTAL_LAT = PIPE_LAT + DIV_LAT + 1;

  localparam int unsigned NEXT1 [AXES] = '{1, 2, 0};
  localparam int unsigned NEXT2 [AXES] = '{2, 0, 1};

  localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_PARALLEL = 2'd1,
    STAT_BEHIND   = 2'd2
  } status_e;

  typedef struct packed {
    logic             neg;
    logic             ovf;
    logic [DEN_W-1:0] den;
    logic [DEN_W-1:0] rem;
    logic [QB-1:0]    lo;
    logic [QB-1:0]    quo;
  } div_stage_t;

endpackage

>>> hdl/two_ray_intersection_midpoint.sv
// Top level: closest-point midpoint of two 3D rays, fully pipelined.
//
// Requests: drive the twelve ray fields and raise start; a request is taken
// at every clock edge with start high and busy low. busy is always low, so a
// new ray pair may enter every cycle.
// Results: done_o is high for exactly one cycle with status_o and point_*_o;
// the receiver cannot hold it off. Each request gives one result, in order.
// The path from the accepting edge to the result runs through 9 arithmetic
// stages (cross products, squared length, the two numerators in split
// multiplies, the midpoint numerator), a 31-stage restoring divider that
// yields one quotient bit per stage per axis, and entry and output
// registers. Throughput is one pair per cycle.
// Configuration: APB write to address 0 sets parallel_threshold (Q0.32);
// write only when no request is in flight. Reads return the register.
// Reset clears the threshold and all valid bits; requests in flight are
// dropped. Status 1 marks parallel rays, 2 a crossing behind an origin;
// the point is zero for both.
module two_ray_intersection_midpoint (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start,
  output logic                                   busy,
  input  logic signed [trim_pkg::POS_W-1:0]      origin_a_x_i,
  input  logic signed [trim_pkg::POS_W-1:0]      origin_a_y_i,
  input  logic signed [trim_pkg::POS_W-1:0]      origin_a_z_i,
  input  logic signed [trim_pkg::DIR_W-1:0]      dir_a_x_i,
  input  logic signed [trim_pkg::DIR_W-1:0]      dir_a_y_i,
  input  logic signed [trim_pkg::DIR_W-1:0]      dir_a_z_i,
  input  logic signed [trim_pkg::POS_W-1:0]      origin_b_x_i,
  input  logic signed [trim_pkg::POS_W-1:0]      origin_b_y_i,
  input  logic signed [trim_pkg::POS_W-1:0]      origin_b_z_i,
  input  logic signed [trim_pkg::DIR_W-1:0]      dir_b_x_i,
  input  logic signed [trim_pkg::DIR_W-1:0]      dir_b_y_i,
  input  logic signed [trim_pkg::DIR_W-1:0]      dir_b_z_i,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic        [trim_pkg::ADDR_W-1:0]     paddr,
  input  logic        [trim_pkg::DATA_W-1:0]     pwdata,
  output logic        [trim_pkg::DATA_W-1:0]     prdata,
  output logic                                   pready,
  output logic                                   done_o,
  output logic        [1:0]                      status_o,
  output logic signed [trim_pkg::POS_W-1:0]      point_x_o,
  output logic signed [trim_pkg::POS_W-1:0]      point_y_o,
  output logic signed [trim_pkg::POS_W-1:0]      point_z_o
);

  localparam int AXES     = trim_pkg::AXES;
  localparam int PIPE_LAT = trim_pkg::PIPE_LAT;
  localparam int DIV_LAT  = trim_pkg::DIV_LAT;

  logic signed [trim_pkg::POS_W-1:0] pa_w [AXES];
  logic signed [trim_pkg::POS_W-1:0] pb_w [AXES];
  logic signed [trim_pkg::DIR_W-1:0] na_w [AXES];
  logic signed [trim_pkg::DIR_W-1:0] nb_w [AXES];

  logic [trim_pkg::THR_W-1:0] thr_q;
  logic [PIPE_LAT:1]          vld_q;

  // stage 1
  logic signed [trim_pkg::CP_W-1:0]  cpa1_q [AXES];
  logic signed [trim_pkg::CP_W-1:0]  cpb1_q [AXES];
  logic signed [trim_pkg::DIF_W-1:0] d1_q   [AXES];
  logic signed [trim_pkg::DIF_W-1:0] s1_q   [AXES];
  logic signed [trim_pkg::DIR_W-1:0] na1_q  [AXES];
  logic signed [trim_pkg::DIR_W-1:0] nb1_q  [AXES];
  // stage 2
  logic signed [trim_pkg::C_W-1:0]   c2_q   [AXES];
  logic signed [trim_pkg::UP_W-1:0]  uba2_q [AXES];
  logic signed [trim_pkg::UP_W-1:0]  ubb2_q [AXES];
  logic signed [trim_pkg::UP_W-1:0]  uaa2_q [AXES];
  logic signed [trim_pkg::UP_W-1:0]  uab2_q [AXES];
  logic signed [trim_pkg::DIF_W-1:0] s2_q   [AXES];
  logic signed [trim_pkg::DIR_W-1:0] na2_q  [AXES];
  logic signed [trim_pkg::DIR_W-1:0] nb2_q  [AXES];
  // stage 3
  logic signed [2*trim_pkg::C_W-1:0] csq_w  [AXES];
  logic signed [trim_pkg::U_W-1:0]   ub3_q  [AXES];
  logic signed [trim_pkg::U_W-1:0]   ua3_q  [AXES];
  logic signed [trim_pkg::C_W-1:0]   c3_q   [AXES];
  logic        [trim_pkg::DD_W-1:0]  sq3_q  [AXES];
  logic signed [trim_pkg::DIF_W-1:0] s3_q   [AXES];
  logic signed [trim_pkg::DIR_W-1:0] na3_q  [AXES];
  logic signed [trim_pkg::DIR_W-1:0] nb3_q  [AXES];
  // stage 4
  logic        [trim_pkg::DD_W-1:0]  dd_w;
  logic signed [trim_pkg::PL_W-1:0]  pal4_q [AXES];
  logic signed [trim_pkg::PH_W-1:0]  pah4_q [AXES];
  logic signed [trim_pkg::PL_W-1:0]  pbl4_q [AXES];
  logic signed [trim_pkg::PH_W-1:0]  pbh4_q [AXES];
  logic signed [trim_pkg::DIF_W-1:0] s4_q   [AXES];
  logic signed [trim_pkg::DIR_W-1:0] na4_q  [AXES];
  logic signed [trim_pkg::DIR_W-1:0] nb4_q  [AXES];
  logic        [trim_pkg::DEN_W-1:0] den4_q;
  logic                              par4_q;
  // stage 5
  logic signed [trim_pkg::SL_W-1:0]  nal5_q, nbl5_q;
  logic signed [trim_pkg::SH_W-1:0]  nah5_q, nbh5_q;
  logic signed [trim_pkg::DIF_W-1:0] s5_q   [AXES];
  logic signed [trim_pkg::DIR_W-1:0] na5_q  [AXES];
  logic signed [trim_pkg::DIR_W-1:0] nb5_q  [AXES];
  logic        [trim_pkg::DEN_W-1:0] den5_q;
  logic                              par5_q;
  // stage 6
  logic signed [trim_pkg::N_W-1:0]   numa6_q, numb6_q;
  logic signed [trim_pkg::DIF_W-1:0] s6_q   [AXES];
  logic signed [trim_pkg::DIR_W-1:0] na6_q  [AXES];
  logic signed [trim_pkg::DIR_W-1:0] nb6_q  [AXES];
  logic        [trim_pkg::DEN_W-1:0] den6_q;
  logic                              par6_q;
  // stage 7
  logic signed [trim_pkg::PN_W-1:0]  pa07_q [AXES];
  logic signed [trim_pkg::PN_W-1:0]  pa17_q [AXES];
  logic signed [trim_pkg::PN2_W-1:0] pa27_q [AXES];
  logic signed [trim_pkg::PN_W-1:0]  pb07_q [AXES];
  logic signed [trim_pkg::PN_W-1:0]  pb17_q [AXES];
  logic signed [trim_pkg::PN2_W-1:0] pb27_q [AXES];
  logic signed [trim_pkg::PD_W-1:0]  pd07_q [AXES];
  logic signed [trim_pkg::PD_W-1:0]  pd17_q [AXES];
  logic        [trim_pkg::DEN_W-1:0] den7_q;
  trim_pkg::status_e                 stat7_q;
  // stage 8
  logic signed [trim_pkg::S_W-1:0]   ta8_q  [AXES];
  logic signed [trim_pkg::S_W-1:0]   tb8_q  [AXES];
  logic signed [trim_pkg::S_W-1:0]   tc8_q  [AXES];
  logic        [trim_pkg::DEN_W-1:0] den8_q;
  trim_pkg::status_e                 stat8_q;
  // stage 9
  logic signed [trim_pkg::S_W-1:0]   s9_q   [AXES];
  logic        [trim_pkg::DEN_W-1:0] den9_q;
  trim_pkg::status_e                 stat9_q;

  // divider and output
  logic [AXES-1:0]                   dvld_w;
  logic signed [trim_pkg::POS_W-1:0] q_w [AXES];
  trim_pkg::status_e                 stat_dly_q [DIV_LAT];
  logic                              done_q;
  trim_pkg::status_e                 status_q;
  logic signed [trim_pkg::POS_W-1:0] point_q [AXES];

  assign busy   = 1'b0;
  assign pready = 1'b1;

  always_comb begin
    pa_w[0] = origin_a_x_i; pa_w[1] = origin_a_y_i; pa_w[2] = origin_a_z_i;
    pb_w[0] = origin_b_x_i; pb_w[1] = origin_b_y_i; pb_w[2] = origin_b_z_i;
    na_w[0] = dir_a_x_i;    na_w[1] = dir_a_y_i;    na_w[2] = dir_a_z_i;
    nb_w[0] = dir_b_x_i;    nb_w[1] = dir_b_y_i;    nb_w[2] = dir_b_z_i;
  end

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
    end else if (psel && penable && pwrite && pready &&
                 paddr[trim_pkg::ADDR_W-1:2] == trim_pkg::REG_PAR_THR) begin
      thr_q <= pwdata;
    end
  end

  assign prdata = (paddr[trim_pkg::ADDR_W-1:2] == trim_pkg::REG_PAR_THR) ? thr_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[PIPE_LAT-1:1], start & ~busy};
    end
  end

  for (genvar k = 0; k < AXES; k++) begin : g_axis
    localparam int unsigned K1 = trim_pkg::NEXT1[k];
    localparam int unsigned K2 = trim_pkg::NEXT2[k];

    assign csq_w[k] = c2_q[k] * c2_q[k];

    always_ff @(posedge clk_i) begin
      // stage 1: direction products, origin difference and sum
      cpa1_q[k] <= na_w[K1] * nb_w[K2];
      cpb1_q[k] <= na_w[K2] * nb_w[K1];
      d1_q[k]   <= trim_pkg::DIF_W'(pb_w[k]) - trim_pkg::DIF_W'(pa_w[k]);
      s1_q[k]   <= trim_pkg::DIF_W'(pb_w[k]) + trim_pkg::DIF_W'(pa_w[k]);
      na1_q[k]  <= na_w[k];
      nb1_q[k]  <= nb_w[k];
      // stage 2: cross product, products of difference with directions
      c2_q[k]   <= trim_pkg::C_W'(cpa1_q[k]) - trim_pkg::C_W'(cpb1_q[k]);
      uba2_q[k] <= d1_q[K1] * nb1_q[K2];
      ubb2_q[k] <= d1_q[K2] * nb1_q[K1];
      uaa2_q[k] <= d1_q[K1] * na1_q[K2];
      uab2_q[k] <= d1_q[K2] * na1_q[K1];
      s2_q[k]   <= s1_q[k];
      na2_q[k]  <= na1_q[k];
      nb2_q[k]  <= nb1_q[k];
      // stage 3
      ub3_q[k]  <= trim_pkg::U_W'(uba2_q[k]) - trim_pkg::U_W'(ubb2_q[k]);
      ua3_q[k]  <= trim_pkg::U_W'(uaa2_q[k]) - trim_pkg::U_W'(uab2_q[k]);
      sq3_q[k]  <= csq_w[k][trim_pkg::DD_W-1:0];
      c3_q[k]   <= c2_q[k];
      s3_q[k]   <= s2_q[k];
      na3_q[k]  <= na2_q[k];
      nb3_q[k]  <= nb2_q[k];
      // stage 4: numerator terms split at ULO_W bits
      pal4_q[k] <= c3_q[k] * $signed({1'b0, ub3_q[k][trim_pkg::ULO_W-1:0]});
      pah4_q[k] <= c3_q[k] * $signed(ub3_q[k][trim_pkg::U_W-1:trim_pkg::ULO_W]);
      pbl4_q[k] <= c3_q[k] * $signed({1'b0, ua3_q[k][trim_pkg::ULO_W-1:0]});
      pbh4_q[k] <= c3_q[k] * $signed(ua3_q[k][trim_pkg::U_W-1:trim_pkg::ULO_W]);
      s4_q[k]   <= s3_q[k];
      na4_q[k]  <= na3_q[k];
      nb4_q[k]  <= nb3_q[k];
      // stages 5 and 6 carry the per-axis operands
      s5_q[k]   <= s4_q[k];
      na5_q[k]  <= na4_q[k];
      nb5_q[k]  <= nb4_q[k];
      s6_q[k]   <= s5_q[k];
      na6_q[k]  <= na5_q[k];
      nb6_q[k]  <= nb5_q[k];
      // stage 7: numerators times directions in chunks, sum times den
      pa07_q[k] <= $signed({1'b0, numa6_q[trim_pkg::NC_W-1:0]}) * na6_q[k];
      pa17_q[k] <= $signed({1'b0, numa6_q[2*trim_pkg::NC_W-1:trim_pkg::NC_W]}) * na6_q[k];
      pa27_q[k] <= $signed(numa6_q[trim_pkg::N_W-1:2*trim_pkg::NC_W]) * na6_q[k];
      pb07_q[k] <= $signed({1'b0, numb6_q[trim_pkg::NC_W-1:0]}) * nb6_q[k];
      pb17_q[k] <= $signed({1'b0, numb6_q[2*trim_pkg::NC_W-1:trim_pkg::NC_W]}) * nb6_q[k];
      pb27_q[k] <= $signed(numb6_q[trim_pkg::N_W-1:2*trim_pkg::NC_W]) * nb6_q[k];
      pd07_q[k] <= s6_q[k] * $signed({1'b0, den6_q[trim_pkg::DC_W-1:0]});
      pd17_q[k] <= s6_q[k] * $signed({1'b0, den6_q[trim_pkg::DEN_W-1:trim_pkg::DC_W]});
      // stage 8
      ta8_q[k]  <= trim_pkg::S_W'(pa07_q[k])
                 + (trim_pkg::S_W'(pa17_q[k]) <<< trim_pkg::NC_W)
                 + (trim_pkg::S_W'(pa27_q[k]) <<< (2 * trim_pkg::NC_W));
      tb8_q[k]  <= trim_pkg::S_W'(pb07_q[k])
                 + (trim_pkg::S_W'(pb17_q[k]) <<< trim_pkg::NC_W)
                 + (trim_pkg::S_W'(pb27_q[k]) <<< (2 * trim_pkg::NC_W));
      tc8_q[k]  <= (trim_pkg::S_W'(pd07_q[k])
                 + (trim_pkg::S_W'(pd17_q[k]) <<< trim_pkg::DC_W)) <<< trim_pkg::DEN_SHIFT;
      // stage 9
      s9_q[k]   <= ta8_q[k] + tb8_q[k] + tc8_q[k];
    end

    trim_div u_div (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .vld_i  (vld_q[PIPE_LAT]),
      .num_i  (s9_q[k]),
      .den_i  (den9_q),
      .vld_o  (dvld_w[k]),
      .quo_o  (q_w[k])
    );
  end

  assign dd_w = sq3_q[0] + sq3_q[1] + sq3_q[2];

  always_ff @(posedge clk_i) begin
    den4_q  <= dd_w[trim_pkg::DD_W-1:trim_pkg::DEN_SHIFT];
    par4_q  <= (dd_w[trim_pkg::DD_W-1:trim_pkg::DEN_SHIFT] == '0) ||
               (dd_w[trim_pkg::DD_W-1:trim_pkg::DEN_SHIFT] < trim_pkg::DEN_W'(thr_q));
    nal5_q  <= trim_pkg::SL_W'(pal4_q[0]) + trim_pkg::SL_W'(pal4_q[1])
             + trim_pkg::SL_W'(pal4_q[2]);
    nah5_q  <= trim_pkg::SH_W'(pah4_q[0]) + trim_pkg::SH_W'(pah4_q[1])
             + trim_pkg::SH_W'(pah4_q[2]);
    nbl5_q  <= trim_pkg::SL_W'(pbl4_q[0]) + trim_pkg::SL_W'(pbl4_q[1])
             + trim_pkg::SL_W'(pbl4_q[2]);
    nbh5_q  <= trim_pkg::SH_W'(pbh4_q[0]) + trim_pkg::SH_W'(pbh4_q[1])
             + trim_pkg::SH_W'(pbh4_q[2]);
    den5_q  <= den4_q;
    par5_q  <= par4_q;
    numa6_q <= (trim_pkg::N_W'(nah5_q) <<< trim_pkg::ULO_W) + trim_pkg::N_W'(nal5_q);
    numb6_q <= (trim_pkg::N_W'(nbh5_q) <<< trim_pkg::ULO_W) + trim_pkg::N_W'(nbl5_q);
    den6_q  <= den5_q;
    par6_q  <= par5_q;
    den7_q  <= den6_q;
    if (par6_q) begin
      stat7_q <= trim_pkg::STAT_PARALLEL;
    end else if (numa6_q[trim_pkg::N_W-1] || numb6_q[trim_pkg::N_W-1]) begin
      stat7_q <= trim_pkg::STAT_BEHIND;
    end else begin
      stat7_q <= trim_pkg::STAT_OK;
    end
    den8_q  <= den7_q;
    stat8_q <= stat7_q;
    den9_q  <= den8_q;
    stat9_q <= stat8_q;
  end

  // status rides alongside the divider
  always_ff @(posedge clk_i) begin
    stat_dly_q[0] <= stat9_q;
  end
  for (genvar i = 1; i < DIV_LAT; i++) begin : g_stat_dly
    always_ff @(posedge clk_i) begin
      stat_dly_q[i] <= stat_dly_q[i-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= &dvld_w;
    end
  end

  for (genvar k = 0; k < AXES; k++) begin : g_out
    always_ff @(posedge clk_i) begin
      point_q[k] <= (stat_dly_q[DIV_LAT-1] == trim_pkg::STAT_OK) ? q_w[k] : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= stat_dly_q[DIV_LAT-1];
  end

  assign done_o    = done_q;
  assign status_o  = status_q;
  assign point_x_o = point_q[0];
  assign point_y_o = point_q[1];
  assign point_z_o = point_q[2];

`ifndef NO_ASSERTIONS
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##(trim_pkg::TOTAL_LAT) done_o)
    else $error("request did not produce a result at the expected latency");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, trim_pkg::TOTAL_LAT))
    else $error("result without a matching request");

  a_zero_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o != trim_pkg::STAT_OK |->
      point_x_o == '0 && point_y_o == '0 && point_z_o == '0)
    else $error("point not cleared for a failed request");

  a_div_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |-> (dvld_w == 3'b000) || (dvld_w == 3'b111))
    else $error("axis dividers out of step");
`endif

endmodule

>>> hdl/trim_div.sv
// Pipelined floor division by den*2^33 with saturation to signed Q16.16.
module trim_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                vld_i,
  input  logic signed [trim_pkg::S_W-1:0]     num_i,
  input  logic        [trim_pkg::DEN_W-1:0]   den_i,
  output logic                                vld_o,
  output logic signed [trim_pkg::POS_W-1:0]   quo_o
);

  localparam int QB    = trim_pkg::QB;
  localparam int DEN_W = trim_pkg::DEN_W;
  localparam int UD_W  = trim_pkg::UD_W;

  logic signed [trim_pkg::SV_W-1:0] sv_w;
  logic                             neg_w;
  logic [UD_W-1:0]                  u_w;
  logic                             ovf_w;
  trim_pkg::div_stage_t             st_q [QB+1];
  trim_pkg::div_stage_t             st_d [QB+1];
  logic [QB:0]                      vld_q;
  logic                             vld_out_q;
  logic signed [trim_pkg::POS_W-1:0] quo_q;

  // floor(x/d) for negative x is ~floor(~x/d), so only an unsigned divide is needed
  always_comb begin
    sv_w  = num_i[trim_pkg::S_W-1:trim_pkg::SHR];
    neg_w = sv_w[trim_pkg::SV_W-1];
    u_w   = neg_w ? ~sv_w[UD_W-1:0] : sv_w[UD_W-1:0];
    ovf_w = u_w >= UD_W'({den_i, {QB{1'b0}}});
    st_d[0].neg = neg_w;
    st_d[0].ovf = ovf_w;
    st_d[0].den = den_i;
    st_d[0].rem = u_w[QB+DEN_W-1:QB];
    st_d[0].lo  = u_w[QB-1:0];
    st_d[0].quo = '0;
  end

  for (genvar i = 1; i <= QB; i++) begin : g_step
    logic [DEN_W:0] rs_w;
    logic [DEN_W:0] dif_w;
    logic           ge_w;
    always_comb begin
      rs_w        = {st_q[i-1].rem, st_q[i-1].lo[QB-1]};
      dif_w       = rs_w - {1'b0, st_q[i-1].den};
      ge_w        = rs_w >= {1'b0, st_q[i-1].den};
      st_d[i]     = st_q[i-1];
      st_d[i].rem = ge_w ? dif_w[DEN_W-1:0] : rs_w[DEN_W-1:0];
      st_d[i].lo  = {st_q[i-1].lo[QB-2:0], 1'b0};
      st_d[i].quo = {st_q[i-1].quo[QB-2:0], ge_w};
    end
  end

  for (genvar i = 0; i <= QB; i++) begin : g_reg
    always_ff @(posedge clk_i) begin
      st_q[i] <= st_d[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q[QB].ovf) begin
      quo_q <= st_q[QB].neg ? trim_pkg::POS_MIN : trim_pkg::POS_MAX;
    end else if (st_q[QB].neg) begin
      quo_q <= ~{1'b0, st_q[QB].quo};
    end else begin
      quo_q <= {1'b0, st_q[QB].quo};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      vld_out_q <= 1'b0;
    end else begin
      vld_q     <= {vld_q[QB-1:0], vld_i};
      vld_out_q <= vld_q[QB];
    end
  end

  assign vld_o = vld_out_q;
  assign quo_o = quo_q;

endmodule
